@@ design/ssk_pkg.sv @@
// shared types, codes and the gap sequence for the shell sort block
package ssk_pkg;

    localparam int GAP_W     = 16;
    localparam int GAP_CNT_W = 4;

    typedef enum logic [1:0] {
        ACT_LOAD      = 2'd0,
        ACT_READ_ELEM = 2'd1,
        ACT_READ_GAP  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_SUMMARY = 2'd0,
        KIND_ELEM    = 2'd1,
        KIND_GAP     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        E_IDLE,
        E_BUILD,
        E_PASS,
        E_OUTER,
        E_HOLD,
        E_INNER,
        E_CMP,
        E_NEXT
    } t_eng_state;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
        logic               is_last;
        logic [9:0]         index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] element_value;
        logic [8:0]         gap_value;
        logic [2:0]         gap_count;
        logic [31:0]        shift_count;
        logic               overflow;
        logic               index_error;
    } t_out_item;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [GAP_CNT_W-1:0] gaps_used;
        logic [31:0]          shift_count;
    } t_eng_stat;

    // knuth sequence, g(i+1) = 3 g(i) + 1
    function automatic logic [GAP_W-1:0] knuth_gap(input logic [GAP_CNT_W-1:0] idx);
        logic [GAP_W-1:0] g;
        unique case (idx)
            4'd0:    g = 16'd1;
            4'd1:    g = 16'd4;
            4'd2:    g = 16'd13;
            4'd3:    g = 16'd40;
            4'd4:    g = 16'd121;
            4'd5:    g = 16'd364;
            4'd6:    g = 16'd1093;
            4'd7:    g = 16'd3280;
            4'd8:    g = 16'd9841;
            4'd9:    g = 16'd29524;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

@@ design/ssk_engine.sv @@
// element store and the sequencer that runs the gapped insertion passes
module ssk_engine
    import ssk_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int MAX_GAPS     = 6,
    localparam int AW  = $clog2(MAX_ELEMENTS),
    localparam int CW  = $clog2(MAX_ELEMENTS + 1),
    localparam int IPW = CW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_count,
    input  logic          i_host_we,
    input  logic [AW-1:0] i_host_addr,
    input  logic [31:0]   i_host_wdata,
    output logic [31:0]   o_rd_data,
    output t_eng_stat     o_stat
);

    logic [31:0] mem [MAX_ELEMENTS];
    logic [31:0] r_rd_data;

    t_eng_state r_state, n_state;
    logic [GAP_CNT_W-1:0] r_gaps, r_pass;
    logic [CW-1:0]        r_outer;
    logic signed [IPW-1:0] r_inner;
    logic [31:0]          r_held;
    logic [31:0]          r_shift;
    logic                 r_done;

    logic [GAP_W-1:0]      w_gap_full;
    logic [CW-1:0]         w_gap;
    logic signed [IPW-1:0] w_gap_s;
    logic signed [IPW-1:0] w_ins_pos;
    logic                  w_grow;
    logic                  w_greater;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_wdata;

    assign w_gap_full = knuth_gap(r_pass);
    assign w_gap      = CW'(w_gap_full);
    assign w_gap_s    = $signed({1'b0, w_gap});
    assign w_ins_pos  = r_inner + w_gap_s;
    assign w_greater  = $signed(r_rd_data) > $signed(r_held);
    assign w_grow     = (r_gaps < GAP_CNT_W'(MAX_GAPS)) &&
                        (32'(knuth_gap(r_gaps)) < 32'(i_count));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            E_IDLE:  if (i_start) n_state = E_BUILD;
            E_BUILD: if (!w_grow) n_state = E_PASS;
            E_PASS:  n_state = E_OUTER;
            E_OUTER: n_state = (r_outer >= i_count) ? E_NEXT : E_HOLD;
            E_HOLD:  n_state = E_INNER;
            E_INNER: n_state = (r_inner < 0) ? E_OUTER : E_CMP;
            E_CMP:   n_state = w_greater ? E_INNER : E_OUTER;
            E_NEXT:  n_state = (r_pass == '0) ? E_IDLE : E_PASS;
            default: n_state = E_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_host_addr;
        w_raddr = i_host_addr;
        w_wdata = i_host_wdata;
        unique case (r_state)
            E_IDLE: begin
                w_we = i_host_we;
            end
            E_OUTER: begin
                w_raddr = AW'(r_outer);
            end
            E_INNER: begin
                w_raddr = AW'(r_inner);
                if (r_inner < 0) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(w_ins_pos);
                    w_wdata = r_held;
                end
            end
            E_CMP: begin
                w_we    = 1'b1;
                w_waddr = AW'(w_ins_pos);
                w_wdata = w_greater ? r_rd_data : r_held;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_gaps  <= '0;
            r_pass  <= '0;
            r_shift <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == E_NEXT) && (r_pass == '0);
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_gaps  <= GAP_CNT_W'(1);
                        r_shift <= '0;
                    end
                end
                E_BUILD: begin
                    if (w_grow) r_gaps <= r_gaps + 1'b1;
                    else        r_pass <= r_gaps - 1'b1;
                end
                E_NEXT: begin
                    if (r_pass != '0) r_pass <= r_pass - 1'b1;
                end
                E_CMP: begin
                    if (w_greater && r_shift != '1) r_shift <= r_shift + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // working registers of the passes
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            E_PASS: r_outer <= w_gap;
            E_HOLD: begin
                r_held  <= r_rd_data;
                r_inner <= $signed({1'b0, r_outer}) - w_gap_s;
            end
            E_INNER: begin
                if (r_inner < 0) r_outer <= CW'(r_outer + 1'b1);
            end
            E_CMP: begin
                if (w_greater) r_inner <= r_inner - w_gap_s;
                else           r_outer <= CW'(r_outer + 1'b1);
            end
            default: begin
                r_held <= r_held;
            end
        endcase
    end

    assign o_rd_data          = r_rd_data;
    assign o_stat.busy        = (r_state != E_IDLE);
    assign o_stat.done        = r_done;
    assign o_stat.gaps_used   = r_gaps;
    assign o_stat.shift_count = r_shift;

endmodule

@@ design/shell_sort_knuth_gaps_top.sv @@
// top level: command decode, load count, read results and sort summary
// loads give no result of their own; element and gap reads answer in the cycle after they are taken
// a last-marked load holds busy through the sort: the gap sequence is built, then one
// insertion pass runs per gap, all through the one registered read port of the store
// the summary strobes in the same cycle that busy first reads low; results cannot be held off
// synchronous active-low reset clears counts, flags and the sequencer; the store is not cleared
module shell_sort_knuth_gaps_top
    import ssk_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int MAX_GAPS     = 6
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    t_eng_stat   w_stat;
    logic [31:0] w_rd_data;

    logic          w_accept;
    logic          w_host_we;
    logic [AW-1:0] w_host_addr;
    logic          w_room;
    logic          w_start_sort;
    logic          w_elem_ok;
    logic          w_gap_ok;
    logic [GAP_W-1:0] w_gap_full;

    logic [CW-1:0] r_count;
    logic          r_overflow;
    logic          r_rd_valid;
    logic [1:0]    r_rd_kind;
    logic          r_rd_err;
    logic          r_rd_use_mem;
    logic [8:0]    r_rd_gap;

    ssk_engine #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_GAPS     (MAX_GAPS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start_sort),
        .i_count      (r_count),
        .i_host_we    (w_host_we),
        .i_host_addr  (w_host_addr),
        .i_host_wdata (i_item.value),
        .o_rd_data    (w_rd_data),
        .o_stat       (w_stat)
    );

    assign busy     = w_stat.busy;
    assign w_accept = start && !busy;
    assign w_room   = 32'(r_count) < 32'(MAX_ELEMENTS);

    assign w_elem_ok = (32'(i_item.index) < 32'(r_count)) &&
                       (32'(i_item.index) < 32'(MAX_ELEMENTS));
    assign w_gap_ok  = (32'(i_item.index) < 32'(w_stat.gaps_used)) &&
                       (32'(i_item.index) < 32'(MAX_GAPS));
    // descending order: index 0 is the largest gap
    assign w_gap_full = knuth_gap(w_stat.gaps_used - GAP_CNT_W'(i_item.index) - 1'b1);

    always_comb begin
        w_host_we    = 1'b0;
        w_start_sort = 1'b0;
        w_host_addr  = AW'(i_item.index);
        if (w_accept && i_item.action == ACT_LOAD) begin
            w_host_we    = w_room;
            w_host_addr  = AW'(r_count);
            w_start_sort = i_item.is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_accept && (i_item.action == ACT_READ_ELEM ||
                                       i_item.action == ACT_READ_GAP);
            if (w_accept && i_item.action == ACT_LOAD) begin
                if (w_room) r_count    <= CW'(r_count + 1'b1);
                else        r_overflow <= 1'b1;
            end
        end
    end

    // read word fields, the element itself comes from the store's read register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (i_item.action == ACT_READ_GAP) begin
                r_rd_kind    <= KIND_GAP;
                r_rd_err     <= !w_gap_ok;
                r_rd_use_mem <= 1'b0;
                r_rd_gap     <= w_gap_ok ? w_gap_full[8:0] : 9'd0;
            end else begin
                r_rd_kind    <= KIND_ELEM;
                r_rd_err     <= !w_elem_ok;
                r_rd_use_mem <= w_elem_ok;
                r_rd_gap     <= 9'd0;
            end
        end
    end

    assign o_valid = r_rd_valid || w_stat.done;

    always_comb begin
        o_result = '0;
        if (w_stat.done) begin
            o_result.kind        = KIND_SUMMARY;
            o_result.gap_count   = 3'(w_stat.gaps_used);
            o_result.shift_count = w_stat.shift_count;
            o_result.overflow    = r_overflow;
        end else begin
            o_result.kind          = r_rd_kind;
            o_result.element_value = r_rd_use_mem ? $signed(w_rd_data) : 32'sd0;
            o_result.gap_value     = r_rd_gap;
            o_result.index_error   = r_rd_err;
        end
    end

    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.done && r_rd_valid))
        else $error("summary and read word in the same cycle");

    a_sort_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.action == ACT_LOAD && i_item.is_last) |=> busy)
        else $error("last load did not start the sort");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> !busy && $past(busy))
        else $error("summary outside the end of a sort");

    a_summary_gaps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> w_stat.gaps_used != '0)
        else $error("summary with no gaps");

endmodule

@@ test/tb_top.sv @@
// self-checking bench for the shell sort block: loads, sorts, element and gap reads
`timescale 1ns / 100ps

module tb_top
    import ssk_pkg::*;
();

    localparam int ELEM_CAP    = 1024;
    localparam int GAP_CAP     = 6;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int TAIL_CYCLES = 20;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        t_in_item word;
        logic     drain;
    } t_pending_word;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_valid;
    t_out_item o_result;

    t_pending_word cmd_q[$];
    t_out_item     answer_q[$];
    t_pending_word cur_cmd;
    t_out_item     want;
    t_out_item     predicted;
    bit            has_answer;

    int errors    = 0;
    int cycle_cnt = 0;
    int idle_left = 0;
    int calm_left = 0;
    int gen_cnt   = 0;

    // predictor state
    int          sorted_store[ELEM_CAP];
    int          sorted_cnt = 0;
    int          gap_seq[GAP_CAP];
    int          gap_seq_n = 0;
    logic [31:0] shift_total = '0;
    logic        store_overflow = 1'b0;

    shell_sort_knuth_gaps_top #(
        .MAX_ELEMENTS(ELEM_CAP),
        .MAX_GAPS    (GAP_CAP)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %h want %h", name, got, exp_val));
    endtask

    task automatic shell_sort_store();
        int k;
        int g;
        int o;
        int p;
        int held;
        shift_total = '0;
        gap_seq[0] = 1;
        gap_seq_n = 1;
        while (gap_seq_n < GAP_CAP && gap_seq[gap_seq_n - 1] * 3 + 1 < sorted_cnt) begin
            gap_seq[gap_seq_n] = gap_seq[gap_seq_n - 1] * 3 + 1;
            gap_seq_n++;
        end
        for (k = gap_seq_n; k > 0; k--) begin
            g = gap_seq[k - 1];
            for (o = g; o < sorted_cnt; o++) begin
                held = sorted_store[o];
                p = o - g;
                while (p >= 0) begin
                    if (sorted_store[p] <= held) break;
                    sorted_store[p + g] = sorted_store[p];
                    p -= g;
                    if (shift_total != 32'hFFFF_FFFF) shift_total++;
                end
                sorted_store[p + g] = held;
            end
        end
    endtask

    task automatic predict_answer(input t_in_item w, output bit has, output t_out_item r);
        r = '0;
        has = 1'b0;
        case (w.action)
            ACT_LOAD: begin
                if (sorted_cnt < ELEM_CAP) begin
                    sorted_store[sorted_cnt] = w.value;
                    sorted_cnt++;
                end else begin
                    store_overflow = 1'b1;
                end
                if (w.is_last) begin
                    shell_sort_store();
                    has = 1'b1;
                    r.kind = KIND_SUMMARY;
                    r.gap_count = gap_seq_n[2:0];
                    r.shift_count = shift_total;
                    r.overflow = store_overflow;
                end
            end
            ACT_READ_ELEM: begin
                has = 1'b1;
                r.kind = KIND_ELEM;
                if (w.index < sorted_cnt) r.element_value = sorted_store[w.index];
                else r.index_error = 1'b1;
            end
            ACT_READ_GAP: begin
                has = 1'b1;
                r.kind = KIND_GAP;
                if (w.index < gap_seq_n)
                    r.gap_value = 9'(gap_seq[gap_seq_n - 1 - w.index]);
                else r.index_error = 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic int pick_idle();
        int roll;
        if (calm_left != 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            calm_left = 40;
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // driver: a word stays on the bus until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_item <= '0;
            idle_left <= 0;
        end else if (!start || !busy) begin
            if (idle_left != 0) begin
                start <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (cmd_q.size() != 0 &&
                         (!cmd_q[0].drain || (!start && answer_q.size() == 0))) begin
                cur_cmd = cmd_q.pop_front();
                start <= 1'b1;
                i_item <= cur_cmd.word;
                idle_left <= pick_idle();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check the answer first, then predict the word taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && $isunknown(o_valid)) report_mismatch("o_valid unknown");
        if (o_valid === 1'b1) begin
            if (answer_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_result));
            end else begin
                want = answer_q.pop_front();
                check_field("kind", o_result.kind, want.kind);
                check_field("element_value", o_result.element_value, want.element_value);
                check_field("gap_value", o_result.gap_value, want.gap_value);
                check_field("gap_count", o_result.gap_count, want.gap_count);
                check_field("shift_count", o_result.shift_count, want.shift_count);
                check_field("overflow", o_result.overflow, want.overflow);
                check_field("index_error", o_result.index_error, want.index_error);
            end
        end
        if (i_rst_n && start && !busy) begin
            predict_answer(i_item, has_answer, predicted);
            if (has_answer) answer_q.insert(answer_q.size(), predicted);
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4, 5:    return $signed($urandom_range(0, 7)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_word(input logic [1:0] act, input logic signed [31:0] val,
                              input logic last, input logic [9:0] idx, input logic drain);
        t_pending_word pw;
        pw.word.action = act;
        pw.word.value = val;
        pw.word.is_last = last;
        pw.word.index = idx;
        pw.drain = drain;
        cmd_q.insert(cmd_q.size(), pw);
        if (act == ACT_LOAD && gen_cnt < ELEM_CAP) gen_cnt++;
    endtask

    task automatic queue_load(input logic last);
        queue_word(ACT_LOAD, pick_value(), last, 10'($urandom_range(0, 1023)), 1'b0);
    endtask

    task automatic queue_read();
        int sel;
        logic drain;
        sel = $urandom_range(0, 19);
        drain = ($urandom_range(0, 63) == 0);
        if (sel < 9)
            queue_word(ACT_READ_ELEM, $urandom, 1'($urandom_range(0, 1)),
                       gen_cnt != 0 ? 10'($urandom_range(0, gen_cnt - 1)) : 10'd0, drain);
        else if (sel < 15)
            queue_word(ACT_READ_GAP, $urandom, 1'($urandom_range(0, 1)),
                       10'($urandom_range(0, GAP_CAP)), drain);
        else if (sel < 17)
            queue_word(ACT_READ_ELEM, $urandom, 1'($urandom_range(0, 1)),
                       10'($urandom_range(0, 1023)), drain);
        else if (sel < 18)
            queue_word(ACT_READ_GAP, $urandom, 1'($urandom_range(0, 1)),
                       10'($urandom_range(0, 1023)), drain);
        else
            queue_word(ACT_UNUSED, $urandom, 1'($urandom_range(0, 1)),
                       10'($urandom_range(0, 1023)), drain);
    endtask

    initial begin
        int b;
        int n;
        int i;

        // reads before anything is loaded or sorted
        queue_word(ACT_READ_ELEM, 32'sd0, 1'b0, 10'd0, 1'b0);
        queue_word(ACT_READ_GAP, 32'sd0, 1'b0, 10'd0, 1'b0);
        queue_word(ACT_UNUSED, -32'sd1, 1'b0, 10'd1023, 1'b0);
        // single element sort
        queue_word(ACT_LOAD, 32'sh7FFF_FFFF, 1'b1, 10'd1023, 1'b0);
        queue_word(ACT_READ_ELEM, 32'sd0, 1'b0, 10'd0, 1'b1);
        queue_word(ACT_READ_ELEM, 32'sd0, 1'b0, 10'd1, 1'b0);
        queue_word(ACT_READ_GAP, 32'sd0, 1'b1, 10'd0, 1'b0);
        queue_word(ACT_READ_GAP, 32'sd0, 1'b0, 10'd5, 1'b0);
        queue_word(ACT_READ_ELEM, 32'sd0, 1'b1, 10'd1023, 1'b0);
        // append after a sort, then sort the whole store again
        queue_word(ACT_LOAD, 32'sh8000_0000, 1'b0, 10'd0, 1'b0);
        queue_word(ACT_LOAD, 32'sd0, 1'b0, 10'd0, 1'b0);
        queue_word(ACT_READ_ELEM, 32'sd0, 1'b0, 10'd2, 1'b0);
        queue_word(ACT_LOAD, -32'sd1, 1'b0, 10'd0, 1'b0);
        queue_word(ACT_LOAD, 32'sd1, 1'b1, 10'd0, 1'b0);
        for (i = 0; i < 5; i++) queue_word(ACT_READ_ELEM, 32'sd0, 1'b0, 10'(i), 1'b0);
        queue_word(ACT_READ_GAP, 32'sd0, 1'b0, 10'd0, 1'b0);
        queue_word(ACT_READ_GAP, 32'sd0, 1'b0, 10'd1, 1'b0);
        queue_word(ACT_READ_GAP, 32'sd0, 1'b0, 10'd2, 1'b0);
        queue_word(ACT_UNUSED, 32'sd0, 1'b1, 10'd0, 1'b0);

        // short load batches with reads in between
        for (b = 0; b < 20; b++) begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0) queue_read();
                queue_load(i == n - 1);
            end
            n = $urandom_range(3, 15);
            for (i = 0; i < n; i++) queue_read();
        end

        // fill the store, run past capacity, then one full-size sort
        while (gen_cnt < ELEM_CAP) begin
            if ($urandom_range(0, 24) == 0) queue_read();
            queue_load(1'b0);
        end
        queue_load(1'b0);
        queue_load(1'b0);
        queue_load(1'b1);
        queue_word(ACT_READ_GAP, $urandom, 1'b0, 10'd0, 1'b1);
        for (i = 0; i < 500; i++) queue_read();

        // dropped load that still sorts an already sorted full store
        queue_load(1'b1);
        for (i = 0; i < 200; i++) queue_read();

        while (cmd_q.size() != 0 || start) @(posedge i_clk);
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/ssk_pkg.sv
design/ssk_engine.sv
design/shell_sort_knuth_gaps_top.sv
test/tb_top.sv
